[design/assert_macros.svh]
// Assertion macros for the sorted tuple key counter.
// Expect signals clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stcc: same-cycle check failed");
`define STCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stcc: next-cycle check failed");
`else
`define STCC_ASSERT_IMP(lbl, ante, cons)
`define STCC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[design/stcc_pkg.sv]
// Package for the sorted tuple key counter: sizes, types, kind codes and key packing.
// No dependencies.
package stcc_pkg;

  localparam int CAPACITY    = 1024;
  localparam int KEY_WORDS   = 2;
  localparam int COUNT_WIDTH = 32;

  localparam int KEY_W  = 32 * KEY_WORDS;
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int OCC_W  = $clog2(CAPACITY + 1);
  localparam int GRP_W  = (IDX_W + 1) / 2;
  localparam int GRP    = 1 << GRP_W;
  localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;
  localparam int GCNT_W = GRP_W + 1;
  localparam int POS_W  = 10;
  localparam int HIT_W  = 32;

  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [OCC_W-1:0]       occ_t;
  typedef logic [GCNT_W-1:0]      gcnt_t;

  localparam cnt_t CNT_MAX = '1;
  localparam cnt_t CNT_ONE = cnt_t'(1);

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic inc_en;
  } stcc_ctl_t;

  // sign bits flipped so unsigned order equals signed word-by-word order
  function automatic key_t pack_key(input logic [31:0] hi, input logic [31:0] lo);
    logic [63:0] both;
    both = {hi ^ SIGN_FLIP, lo ^ SIGN_FLIP};
    if (KEY_WORDS > 1) begin
      pack_key = key_t'(both);
    end else begin
      pack_key = key_t'(hi ^ SIGN_FLIP);
    end
  endfunction

endpackage

[design/stcc_cell.sv]
// One table slot: key, count, and registered compare flags against the probe key.
// Shifts from its lower neighbor on insert. Depends on stcc_pkg.
module stcc_cell import stcc_pkg::*; (
  input  logic      clk,
  input  stcc_ctl_t ctl,
  input  key_t      probe,
  input  logic      live,
  input  logic      prev_lt,
  input  key_t      prev_key,
  input  cnt_t      prev_cnt,
  output key_t      key_o,
  output cnt_t      cnt_o,
  output logic      lt_o,
  output logic      eq_o
);

  key_t key_r, key_nxt;
  cnt_t cnt_r, cnt_nxt;
  logic lt_r, lt_nxt;
  logic eq_r, eq_nxt;

  always_comb begin
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    if (ctl.cmp_en) begin
      lt_nxt = live && (key_r < probe);
      eq_nxt = live && (key_r == probe);
    end
    if (ctl.ins_en && !lt_r) begin
      if (prev_lt) begin
        key_nxt = probe;
        cnt_nxt = CNT_ONE;
      end else begin
        key_nxt = prev_key;
        cnt_nxt = prev_cnt;
      end
    end else if (ctl.inc_en && eq_r && (cnt_r != CNT_MAX)) begin
      cnt_nxt = cnt_r + CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    cnt_r <= cnt_nxt;
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
  end

  assign key_o = key_r;
  assign cnt_o = cnt_r;
  assign lt_o  = lt_r;
  assign eq_o  = eq_r;

endmodule

[design/stcc_group.sv]
// Registered reduction over one group of cells: count of lower keys, match and its count.
// Depends on stcc_pkg.
module stcc_group import stcc_pkg::*; (
  input  logic  clk,
  input  logic  lt_i [GRP],
  input  logic  eq_i [GRP],
  input  cnt_t  cnt_i [GRP],
  output gcnt_t cnt_o,
  output logic  all_lt_o,
  output logic  eq_o,
  output cnt_t  hit_o
);

  gcnt_t cnt_r, cnt_nxt;
  logic  all_lt_r, all_lt_nxt;
  logic  eq_r, eq_nxt;
  cnt_t  hit_r, hit_nxt;

  // lt flags form a thermometer; its top edge gives the count
  always_comb begin
    logic [GRP:0] ltv;
    ltv      = '0;
    cnt_nxt  = '0;
    eq_nxt   = 1'b0;
    hit_nxt  = '0;
    for (int j = 0; j < GRP; j++) begin
      ltv[j] = lt_i[j];
    end
    for (int j = 0; j < GRP; j++) begin
      if (ltv[j] && !ltv[j+1]) begin
        cnt_nxt = cnt_nxt | gcnt_t'(j + 1);
      end
      if (eq_i[j]) begin
        hit_nxt = hit_nxt | cnt_i[j];
      end
      eq_nxt = eq_nxt | eq_i[j];
    end
    all_lt_nxt = (cnt_nxt == gcnt_t'(GRP));
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    all_lt_r <= all_lt_nxt;
    eq_r     <= eq_nxt;
    hit_r    <= hit_nxt;
  end

  assign cnt_o    = cnt_r;
  assign all_lt_o = all_lt_r;
  assign eq_o     = eq_r;
  assign hit_o    = hit_r;

endmodule

[design/sorted_tuple_key_counter_top.sv]
// Top level of the sorted tuple key counter: cell row, group reduction, control.
// Depends on stcc_pkg, stcc_cell, stcc_group and assert_macros.svh.
//
// Usage:
//   Input channel in_valid/in_ready carries in_kind (0 push, 1 query) and a
//   two-word signed key in_key_hi/in_key_lo. Output channel out_valid/out_ready
//   returns one item per input: out_found, out_position, out_hit_count and
//   out_table_full.
//   Keys live in a row of cells kept in ascending order. An item passes
//   through broadcast compare in every cell, group reduction, final
//   reduction, then the update (count increment or shift-up insert) together
//   with loading the output register. The next item can be accepted in that
//   same update cycle.
//   If the receiver stalls, one finished result waits in the output
//   register, one more item is accepted and runs up to its update, and then
//   in_ready stays low until the waiting result is taken.
//   Reset empties the table by clearing the occupancy count; stored keys and
//   counts are not cleared and need no clearing pass.
`include "assert_macros.svh"

module sorted_tuple_key_counter_top import stcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic signed [31:0] in_key_hi,
  input  logic signed [31:0] in_key_lo,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [POS_W-1:0]  out_position,
  output logic [HIT_W-1:0]  out_hit_count,
  output logic              out_table_full
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_GRP  = 5'b00100,
    S_TOP  = 5'b01000,
    S_RES  = 5'b10000
  } state_t;

  state_t st_r, st_nxt;
  key_t   probe_r, probe_nxt;
  logic   kind_r, kind_nxt;
  occ_t   occ_r, occ_nxt;
  occ_t   place_r, place_nxt;
  logic   found_r, found_nxt;
  cnt_t   hit_r, hit_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [POS_W-1:0] out_position_r, out_position_nxt;
  logic [HIT_W-1:0] out_hit_count_r, out_hit_count_nxt;
  logic             out_table_full_r, out_table_full_nxt;

  stcc_ctl_t ctl;
  logic      res_fire;
  logic      accept;
  logic      full;
  logic      do_ins;

  key_t cell_key [CAPACITY];
  cnt_t cell_cnt [CAPACITY];
  logic cell_lt  [CAPACITY];
  logic cell_eq  [CAPACITY];

  gcnt_t grp_cnt [NGRP];
  logic  grp_all [NGRP];
  logic  grp_eq  [NGRP];
  cnt_t  grp_hit [NGRP];

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic cell_live;
    logic nb_lt;
    key_t nb_key;
    cnt_t nb_cnt;
    assign cell_live = (occ_t'(i) < occ_r);
    if (i == 0) begin : g_first
      assign nb_lt  = 1'b1;
      assign nb_key = probe_r;
      assign nb_cnt = CNT_ONE;
    end else begin : g_rest
      assign nb_lt  = cell_lt[i-1];
      assign nb_key = cell_key[i-1];
      assign nb_cnt = cell_cnt[i-1];
    end
    stcc_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .probe    (probe_r),
      .live     (cell_live),
      .prev_lt  (nb_lt),
      .prev_key (nb_key),
      .prev_cnt (nb_cnt),
      .key_o    (cell_key[i]),
      .cnt_o    (cell_cnt[i]),
      .lt_o     (cell_lt[i]),
      .eq_o     (cell_eq[i])
    );
  end

  // group reduction
  for (genvar gi = 0; gi < NGRP; gi++) begin : g_grp
    logic glt [GRP];
    logic geq [GRP];
    cnt_t gcv [GRP];
    for (genvar ci = 0; ci < GRP; ci++) begin : g_slot
      if (gi * GRP + ci < CAPACITY) begin : g_on
        assign glt[ci] = cell_lt[gi*GRP+ci];
        assign geq[ci] = cell_eq[gi*GRP+ci];
        assign gcv[ci] = cell_cnt[gi*GRP+ci];
      end else begin : g_off
        assign glt[ci] = 1'b0;
        assign geq[ci] = 1'b0;
        assign gcv[ci] = '0;
      end
    end
    stcc_group u_grp (
      .clk      (clk),
      .lt_i     (glt),
      .eq_i     (geq),
      .cnt_i    (gcv),
      .cnt_o    (grp_cnt[gi]),
      .all_lt_o (grp_all[gi]),
      .eq_o     (grp_eq[gi]),
      .hit_o    (grp_hit[gi])
    );
  end

  // final reduction: first group not fully below the probe holds the place
  always_comb begin
    logic [NGRP:0] prev_all;
    occ_t          acc;
    logic          any_b;
    logic          bnd;
    prev_all = '0;
    acc      = '0;
    any_b    = 1'b0;
    found_nxt = 1'b0;
    hit_nxt   = '0;
    prev_all[0] = 1'b1;
    for (int g = 0; g < NGRP; g++) begin
      prev_all[g+1] = grp_all[g];
    end
    for (int g = 0; g < NGRP; g++) begin
      bnd   = !grp_all[g] && prev_all[g];
      any_b = any_b | bnd;
      if (bnd) begin
        acc = acc | occ_t'(g * GRP) | occ_t'(grp_cnt[g]);
      end
      found_nxt = found_nxt | grp_eq[g];
      hit_nxt   = hit_nxt | grp_hit[g];
    end
    place_nxt = any_b ? acc : occ_t'(CAPACITY);
  end

  assign full     = (occ_r == occ_t'(CAPACITY));
  assign res_fire = (st_r == S_RES) && (!out_valid_r || out_ready);
  assign in_ready = (st_r == S_IDLE) || res_fire;
  assign accept   = in_valid && in_ready;
  assign do_ins   = (kind_r == KIND_PUSH) && !found_r && !full;

  assign ctl.cmp_en = (st_r == S_CMP);
  assign ctl.ins_en = res_fire && do_ins;
  assign ctl.inc_en = res_fire && found_r && (kind_r == KIND_PUSH);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (in_valid) st_nxt = S_CMP;
      S_CMP:   st_nxt = S_GRP;
      S_GRP:   st_nxt = S_TOP;
      S_TOP:   st_nxt = S_RES;
      S_RES: begin
        if (res_fire) begin
          st_nxt = in_valid ? S_CMP : S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    probe_nxt = probe_r;
    kind_nxt  = kind_r;
    if (accept) begin
      probe_nxt = pack_key(in_key_hi, in_key_lo);
      kind_nxt  = in_kind;
    end
    occ_nxt = ctl.ins_en ? occ_r + occ_t'(1) : occ_r;
  end

  always_comb begin
    out_valid_nxt      = out_valid_r && !out_ready;
    out_found_nxt      = out_found_r;
    out_position_nxt   = out_position_r;
    out_hit_count_nxt  = out_hit_count_r;
    out_table_full_nxt = out_table_full_r;
    if (res_fire) begin
      out_valid_nxt      = 1'b1;
      out_found_nxt      = found_r;
      out_position_nxt   = '0;
      out_hit_count_nxt  = '0;
      out_table_full_nxt = 1'b0;
      if (found_r) begin
        out_position_nxt = POS_W'(place_r);
        if (kind_r == KIND_PUSH && hit_r != CNT_MAX) begin
          out_hit_count_nxt = HIT_W'(hit_r + CNT_ONE);
        end else begin
          out_hit_count_nxt = HIT_W'(hit_r);
        end
      end else if (kind_r == KIND_PUSH) begin
        if (full) begin
          out_table_full_nxt = 1'b1;
        end else begin
          out_position_nxt  = POS_W'(place_r);
          out_hit_count_nxt = HIT_W'(CNT_ONE);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r          <= probe_nxt;
    kind_r           <= kind_nxt;
    out_found_r      <= out_found_nxt;
    out_position_r   <= out_position_nxt;
    out_hit_count_r  <= out_hit_count_nxt;
    out_table_full_r <= out_table_full_nxt;
    if (st_r == S_TOP) begin
      place_r <= place_nxt;
      found_r <= found_nxt;
      hit_r   <= hit_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_position   = out_position_r;
  assign out_hit_count  = out_hit_count_r;
  assign out_table_full = out_table_full_r;

  `STCC_ASSERT_NXT(a_occ_hold, !ctl.ins_en, $stable(occ_r))
  `STCC_ASSERT_IMP(a_ins_room, ctl.ins_en, occ_r < occ_t'(CAPACITY))
  `STCC_ASSERT_IMP(a_full_flag, out_valid_r && out_table_full_r, occ_r == occ_t'(CAPACITY))
  `STCC_ASSERT_IMP(a_found_cnt, out_valid_r && out_found_r, out_hit_count_r != '0)

endmodule

[tb/sv/sorted_tuple_key_counter_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for sorted_tuple_key_counter_top: pushes and queries of
// two-word signed keys, predicted by a sorted table in a small scoreboard class.
// Depends on stcc_pkg and the sorted_tuple_key_counter_top RTL.
module sorted_tuple_key_counter_top_tb;
  import stcc_pkg::*;

  localparam int HOLD_CYCLES  = 60;
  localparam int RANDOM_ITEMS = 600;
  localparam int POOL_DEPTH   = 48;
  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] W_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [HIT_W-1:0] hit_count;
    logic             table_full;
  } tally_t;

  class tally_board;
    logic signed [31:0]     key_hi [CAPACITY];
    logic signed [31:0]     key_lo [CAPACITY];
    logic [COUNT_WIDTH-1:0] counts [CAPACITY];
    int     fill = 0;
    tally_t pending_q[$];
    int     errors = 0;
    int     results = 0;
    int     inserts = 0;
    int     bumps = 0;
    int     lookups = 0;
    int     misses = 0;
    int     rejects = 0;

    function bit key_below(logic signed [31:0] ah, logic signed [31:0] al,
                           logic signed [31:0] bh, logic signed [31:0] bl);
      return (ah < bh) || (KEY_WORDS > 1 && ah == bh && al < bl);
    endfunction

    function bit key_same(logic signed [31:0] ah, logic signed [31:0] al,
                          logic signed [31:0] bh, logic signed [31:0] bl);
      return (ah == bh) && (KEY_WORDS < 2 || al == bl);
    endfunction

    // first entry not below the key
    function int lower_place(logic signed [31:0] khi, logic signed [31:0] klo);
      int low_i;
      int high_i;
      int mid;
      low_i  = 0;
      high_i = fill;
      while (low_i < high_i) begin
        mid = (low_i + high_i) / 2;
        if (key_below(key_hi[mid], key_lo[mid], khi, klo)) begin
          low_i = mid + 1;
        end else begin
          high_i = mid;
        end
      end
      return low_i;
    endfunction

    function void note_item(logic kind, logic signed [31:0] khi, logic signed [31:0] klo);
      tally_t want;
      int     place;
      int     i;
      want  = '0;
      place = lower_place(khi, klo);
      if (place < fill && key_same(key_hi[place], key_lo[place], khi, klo)) begin
        if (kind == KIND_PUSH) begin
          if (counts[place] != CNT_MAX) counts[place] = counts[place] + 1'b1;
          bumps++;
        end else begin
          lookups++;
        end
        want.found     = 1'b1;
        want.position  = POS_W'(place);
        want.hit_count = HIT_W'(counts[place]);
      end else if (kind == KIND_QUERY) begin
        misses++;
      end else if (fill >= CAPACITY) begin
        want.table_full = 1'b1;
        rejects++;
      end else begin
        for (i = fill; i > place; i--) begin
          key_hi[i] = key_hi[i-1];
          key_lo[i] = key_lo[i-1];
          counts[i] = counts[i-1];
        end
        key_hi[place]  = khi;
        key_lo[place]  = klo;
        counts[place]  = CNT_ONE;
        fill++;
        inserts++;
        want.position  = POS_W'(place);
        want.hit_count = HIT_W'(1);
      end
      pending_q.push_back(want);
    endfunction

    function void compare_field(string what, logic [HIT_W-1:0] want, logic [HIT_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(logic found, logic [POS_W-1:0] pos,
                               logic [HIT_W-1:0] hit, logic full);
      tally_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with no item outstanding, expected none, actual %0b/%0d/%0d/%0b",
                 $time, found, pos, hit, full);
      end else begin
        want = pending_q.pop_front();
        results++;
        compare_field("found", HIT_W'(want.found), HIT_W'(found));
        compare_field("position", HIT_W'(want.position), HIT_W'(pos));
        compare_field("hit_count", want.hit_count, hit);
        compare_field("table_full", HIT_W'(want.table_full), HIT_W'(full));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_kind;
  logic signed [31:0] in_key_hi;
  logic signed [31:0] in_key_lo;
  logic              out_valid;
  logic              out_ready;
  logic              out_found;
  logic [POS_W-1:0]  out_position;
  logic [HIT_W-1:0]  out_hit_count;
  logic              out_table_full;

  tally_board board = new;
  bit idle_tx = 1'b1;
  bit idle_rx = 1'b1;
  bit hold_req = 1'b0;
  logic signed [31:0] pool_hi[$];
  logic signed [31:0] pool_lo[$];

  sorted_tuple_key_counter_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_key_hi     (in_key_hi),
    .in_key_lo     (in_key_lo),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_position  (out_position),
    .out_hit_count (out_hit_count),
    .out_table_full(out_table_full)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic drop_valid();
    if (in_valid) in_valid <= 1'b0;
  endtask

  task automatic send_item(logic kind, logic signed [31:0] khi, logic signed [31:0] klo);
    int gap;
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_key_hi <= khi;
    in_key_lo <= klo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(kind, khi, klo);
    gap = (idle_tx && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    drop_valid();
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic remember_key(logic signed [31:0] khi, logic signed [31:0] klo);
    pool_hi.push_back(khi);
    pool_lo.push_back(klo);
    if (pool_hi.size() > POOL_DEPTH) begin
      void'(pool_hi.pop_front());
      void'(pool_lo.pop_front());
    end
  endtask

  function automatic logic signed [31:0] edge_word();
    case ($urandom_range(0, 3))
      0:       return W_MIN;
      1:       return W_MAX;
      2:       return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  // mostly revisits recent keys so counts climb; fresh keys cluster, hit extremes or are fully random
  task automatic pick_key(output logic signed [31:0] khi, output logic signed [31:0] klo);
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 55 && pool_hi.size() > 0) begin
      k   = $urandom_range(0, pool_hi.size() - 1);
      khi = pool_hi[k];
      klo = pool_lo[k];
      if (r >= 45) klo = $urandom_range(0, 1) ? klo + 1 : klo - 1;
    end else begin
      if (r < 70) begin
        khi = $signed($urandom_range(0, 8)) - 4;
        klo = $signed($urandom_range(0, 8)) - 4;
      end else if (r < 78) begin
        khi = edge_word();
        klo = edge_word();
      end else begin
        khi = $urandom;
        klo = $urandom;
      end
      remember_key(khi, klo);
    end
  endtask

  initial begin : result_side
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        board.check_result(out_found, out_position, out_hit_count, out_table_full);
      end
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (idle_rx && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic signed [31:0] khi;
    logic signed [31:0] klo;
    logic               kind;
    int                 n;
    in_valid  <= 1'b0;
    in_kind   <= KIND_PUSH;
    in_key_hi <= '0;
    in_key_lo <= '0;
    rst_n     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, word extremes, equal high words, signed wrap of the difference
    send_item(KIND_QUERY, 32'sd0, 32'sd0);
    send_item(KIND_PUSH, 32'sd0, 32'sd0);
    send_item(KIND_PUSH, 32'sd0, 32'sd0);
    send_item(KIND_PUSH, W_MIN, W_MIN);
    send_item(KIND_PUSH, W_MAX, W_MAX);
    send_item(KIND_PUSH, W_MIN, W_MAX);
    send_item(KIND_PUSH, W_MAX, W_MIN);
    send_item(KIND_PUSH, -32'sd1, -32'sd1);
    send_item(KIND_PUSH, -32'sd1, 32'sd0);
    send_item(KIND_PUSH, 32'sd0, -32'sd1);
    send_item(KIND_PUSH, 32'sd1, 32'sd1);
    send_item(KIND_PUSH, W_MAX, 32'sd0);
    send_item(KIND_PUSH, W_MIN, 32'sd0);
    send_item(KIND_PUSH, 32'sd0, W_MAX);
    send_item(KIND_PUSH, 32'sd0, W_MIN);
    send_item(KIND_QUERY, W_MAX, W_MAX);
    send_item(KIND_QUERY, W_MIN, W_MIN);
    send_item(KIND_QUERY, 32'sd5, 32'sd5);
    send_item(KIND_QUERY, -32'sd1, -32'sd1);
    send_item(KIND_PUSH, W_MAX, W_MAX);
    send_item(KIND_PUSH, W_MIN, W_MIN);
    send_item(KIND_QUERY, 32'sd0, 32'sd0);
    wait_drained();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        idle_tx = $urandom_range(0, 1);
        idle_rx = $urandom_range(0, 1);
      end
      if (n == 300) begin
        // receiver backs off while items keep coming
        idle_tx  = 1'b0;
        hold_req = 1'b1;
      end
      if (n == 450) wait_drained();
      pick_key(khi, klo);
      kind = ($urandom_range(0, 3) == 0) ? KIND_QUERY : KIND_PUSH;
      send_item(kind, khi, klo);
    end
    wait_drained();

    idle_tx = 1'b1;
    idle_rx = 1'b1;
    while (board.fill < CAPACITY) begin
      if ($urandom_range(0, 7) == 0 && pool_hi.size() > 0) begin
        pick_key(khi, klo);
        send_item($urandom_range(0, 1) ? KIND_QUERY : KIND_PUSH, khi, klo);
      end else begin
        send_item(KIND_PUSH, $urandom, $urandom);
      end
    end

    // full table, no idling from here on
    idle_tx = 1'b0;
    idle_rx = 1'b0;
    for (n = 0; n < 4; n++) send_item(KIND_PUSH, $urandom, $urandom);
    send_item(KIND_PUSH, W_MIN, W_MIN + 1);
    for (n = 0; n < 3; n++) send_item(KIND_QUERY, $urandom, $urandom);
    send_item(KIND_PUSH, W_MAX, W_MAX);
    send_item(KIND_QUERY, W_MAX, W_MAX);
    send_item(KIND_QUERY, W_MIN, W_MIN);
    for (n = 0; n < 8; n++) begin
      pick_key(khi, klo);
      send_item(n[0] ? KIND_QUERY : KIND_PUSH, khi, klo);
    end
    wait_drained();
    repeat (12) @(posedge clk);

    $display("%0d results checked: %0d inserts, %0d repeat pushes, %0d rejected on a full table,",
             board.results, board.inserts, board.bumps, board.rejects);
    $display("%0d queries found, %0d queries missed; table reached %0d keys",
             board.lookups, board.misses, board.fill);
    if (board.errors == 0) begin
      $display("sorted_tuple_key_counter_top_tb passed");
    end else begin
      $display("sorted_tuple_key_counter_top_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("timeout with %0d results outstanding", board.pending_q.size());
    $display("sorted_tuple_key_counter_top_tb failed");
    $finish;
  end

endmodule
